@@ hdl/thw_pkg.sv @@
package thw_pkg;

    localparam int NUM_TASKS = 4;
    localparam int TASK_W    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int MASK_W    = 4;
    localparam int TIME_W    = 32;
    localparam int RETRY_W   = 8;
    localparam int OP_W      = 3;
    localparam int IDX_IN_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [TIME_W-1:0]  RESET_TIMEOUT_TICKS = 32'd3000;
    localparam logic [RETRY_W-1:0] RESET_RETRY_LIMIT   = 8'd3;

    localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
    localparam logic [OP_W-1:0] OP_KICK     = 3'd1;
    localparam logic [OP_W-1:0] OP_REGISTER = 3'd2;
    localparam logic [OP_W-1:0] OP_PROGRESS = 3'd3;
    localparam logic [OP_W-1:0] OP_CHECK    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY   = 1'd1;

    typedef struct packed {
        logic [TIME_W-1:0]  last_kick;
        logic [TIME_W-1:0]  progress;
        logic [TIME_W-1:0]  snapshot;
        logic [RETRY_W-1:0] retries;
    } task_entry_t;

    // per-field write enables; fields not enabled keep their value, or are zeroed on the first write to an entry
    typedef struct packed {
        logic              en;
        logic [TASK_W-1:0] addr;
        logic              kick_en;
        logic              count_en;
        logic              snap_en;
        logic              retry_en;
        task_entry_t       data;
    } mem_wr_t;

endpackage

@@ hdl/task_health_watchdog.sv @@
// Tick, kick and register act on acceptance and unused op codes are ignored; a progress bump
//   reads the entry, then writes count + 1 in ST_BUMP. A check sweeps one task entry per cycle
//   from the memory read port, then loads the output register from ST_DONE.
// A new transaction is taken only in ST_IDLE, once the previous one is done; a check stays
//   in ST_DONE while the previous result still sits unaccepted on the result channel.
// Sync reset clears time, valid bits, state and output valid; timeout 3000, retry limit 3.
module task_health_watchdog (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [thw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [thw_pkg::CFG_W-1:0]     cfg_wr_data,
    // event input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [thw_pkg::OP_W-1:0]      s_op,
    input  logic [thw_pkg::IDX_IN_W-1:0]  s_task_index,
    // check result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [thw_pkg::MASK_W-1:0]    m_timeout_mask,
    output logic [thw_pkg::MASK_W-1:0]    m_stuck_mask,
    output logic [thw_pkg::MASK_W-1:0]    m_exhausted_mask,
    output logic                          m_system_healthy,
    output logic                          m_feed_watchdog
);
    import thw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BUMP  = 4'b0010,   // entry read back, write count + 1
        ST_CHECK = 4'b0100,   // one task entry per cycle
        ST_DONE  = 4'b1000    // wait for a free output register
    } state_t;

    state_t state_reg, state_next;

    logic [TIME_W-1:0]  timeout_reg;
    logic [RETRY_W-1:0] retry_limit_reg;
    logic [TIME_W-1:0]  time_reg;

    logic [TASK_W-1:0]  addr_reg, addr_next;   // bump target or sweep position
    logic [MASK_W-1:0]  tmask_reg, tmask_next;
    logic [MASK_W-1:0]  smask_reg, smask_next;
    logic [MASK_W-1:0]  emask_reg, emask_next;
    logic               healthy_reg, healthy_next;
    logic               recovered_reg, recovered_next;

    logic               m_valid_reg;
    logic [MASK_W-1:0]  m_tmask_reg, m_smask_reg, m_emask_reg;
    logic               m_healthy_reg, m_feed_reg;

    logic               rd_en;
    logic [TASK_W-1:0]  rd_addr;
    task_entry_t        rd_data;
    mem_wr_t            wr;

    logic               accept;
    logic               idx_ok;
    logic [TASK_W-1:0]  in_addr;
    logic               out_free;
    logic               load_out;

    // per-task evaluation in the sweep
    logic [TIME_W-1:0]  elapsed;
    logic               timed_out;
    logic               stuck;
    logic               faulted;
    logic               can_retry;
    logic [MASK_W-1:0]  task_bit;
    logic               last_task;

    thw_task_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr      (wr)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign idx_ok   = (32'(s_task_index) < NUM_TASKS);
    assign in_addr  = TASK_W'(s_task_index);
    assign out_free = !m_valid_reg || m_ready;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg     <= RESET_TIMEOUT_TICKS;
            retry_limit_reg <= RESET_RETRY_LIMIT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TIMEOUT: timeout_reg     <= cfg_wr_data;
                CFG_RETRY:   retry_limit_reg <= cfg_wr_data[RETRY_W-1:0];
                default: ;
            endcase
        end
    end

    // tick counter, advanced only by tick transactions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
        end else if (accept && s_op == OP_TICK) begin
            time_reg <= time_reg + 1'b1;
        end
    end

    // sweep evaluation of the entry now on the read port
    assign elapsed   = time_reg - rd_data.last_kick;
    assign timed_out = (elapsed > timeout_reg);
    assign stuck     = !timed_out && (rd_data.progress == rd_data.snapshot);
    assign faulted   = timed_out || stuck;
    assign can_retry = (rd_data.retries < retry_limit_reg);
    // tasks past the mask width still count toward the summary flags
    assign task_bit  = (32'(addr_reg) < MASK_W) ? (MASK_W'(1) << addr_reg) : '0;
    assign last_task = (addr_reg == TASK_W'(NUM_TASKS - 1));

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        tmask_next     = tmask_reg;
        smask_next     = smask_reg;
        emask_next     = emask_reg;
        healthy_next   = healthy_reg;
        recovered_next = recovered_reg;
        rd_en          = 1'b0;
        rd_addr        = in_addr;
        wr             = '0;
        load_out       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_op) inside
                        OP_KICK, OP_REGISTER: begin
                            if (idx_ok) begin
                                wr.en             = 1'b1;
                                wr.addr           = in_addr;
                                wr.kick_en        = 1'b1;
                                wr.data.last_kick = time_reg;
                            end
                        end
                        OP_PROGRESS: begin
                            if (idx_ok) begin
                                rd_en      = 1'b1;
                                addr_next  = in_addr;
                                state_next = ST_BUMP;
                            end
                        end
                        OP_CHECK: begin
                            rd_en          = 1'b1;
                            rd_addr        = '0;
                            addr_next      = '0;
                            tmask_next     = '0;
                            smask_next     = '0;
                            emask_next     = '0;
                            healthy_next   = 1'b1;
                            recovered_next = 1'b1;
                            state_next     = ST_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_BUMP: begin
                wr.en            = 1'b1;
                wr.addr          = addr_reg;
                wr.count_en      = 1'b1;
                wr.data.progress = rd_data.progress + 1'b1;
                state_next       = ST_IDLE;
            end
            ST_CHECK: begin
                wr.addr          = addr_reg;
                wr.data.snapshot = rd_data.progress;
                wr.data.retries  = rd_data.retries + 1'b1;
                if (timed_out) begin
                    tmask_next = tmask_reg | task_bit;
                end
                if (stuck) begin
                    smask_next = smask_reg | task_bit;
                end
                if (!faulted) begin
                    wr.en      = 1'b1;
                    wr.snap_en = 1'b1;
                end else begin
                    healthy_next = 1'b0;
                    if (can_retry) begin
                        wr.en       = 1'b1;
                        wr.retry_en = 1'b1;
                    end else begin
                        emask_next     = emask_reg | task_bit;
                        recovered_next = 1'b0;
                    end
                end
                if (last_task) begin
                    state_next = ST_DONE;
                end else begin
                    // next entry differs from the one written this cycle
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg      <= addr_next;
        tmask_reg     <= tmask_next;
        smask_reg     <= smask_next;
        emask_reg     <= emask_next;
        healthy_reg   <= healthy_next;
        recovered_reg <= recovered_next;
    end

    // result register: holds a finished check while new events are taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tmask_reg   <= tmask_reg;
            m_smask_reg   <= smask_reg;
            m_emask_reg   <= emask_reg;
            m_healthy_reg <= healthy_reg;
            m_feed_reg    <= healthy_reg || recovered_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_timeout_mask   = m_tmask_reg;
    assign m_stuck_mask     = m_smask_reg;
    assign m_exhausted_mask = m_emask_reg;
    assign m_system_healthy = m_healthy_reg;
    assign m_feed_watchdog  = m_feed_reg;

    // a task is never both timed out and stuck in one check
    a_mask_disjoint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_timeout_mask & m_stuck_mask) == '0))
        else $error("timeout and stuck masks overlap");

    // exhausted only applies to faulted tasks
    a_exhaust_subset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_exhausted_mask & ~(m_timeout_mask | m_stuck_mask)) == '0))
        else $error("exhausted task without a fault");

    // healthy check reports no faults and always feeds
    a_healthy_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_system_healthy) |->
            (m_feed_watchdog && (m_timeout_mask | m_stuck_mask) == '0))
        else $error("healthy result carries faults or withholds feed");

    // sweep ends with the result loaded or held for a free output register
    a_sweep_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK && last_task) |=> (state_reg == ST_DONE && !s_ready))
        else $error("check sweep did not terminate");

endmodule

@@ hdl/thw_task_mem.sv @@
module thw_task_mem (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [thw_pkg::TASK_W-1:0] rd_addr,
    output thw_pkg::task_entry_t      rd_data,
    input  thw_pkg::mem_wr_t          wr
);
    import thw_pkg::*;

    task_entry_t mem [NUM_TASKS];
    logic [NUM_TASKS-1:0] valid_reg;
    task_entry_t rd_data_reg;

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            if (wr.kick_en) begin
                mem[wr.addr].last_kick <= wr.data.last_kick;
            end else if (!valid_reg[wr.addr]) begin
                mem[wr.addr].last_kick <= '0;
            end
            if (wr.count_en) begin
                mem[wr.addr].progress <= wr.data.progress;
            end else if (!valid_reg[wr.addr]) begin
                mem[wr.addr].progress <= '0;
            end
            if (wr.snap_en) begin
                mem[wr.addr].snapshot <= wr.data.snapshot;
            end else if (!valid_reg[wr.addr]) begin
                mem[wr.addr].snapshot <= '0;
            end
            if (wr.retry_en) begin
                mem[wr.addr].retries <= wr.data.retries;
            end else if (!valid_reg[wr.addr]) begin
                mem[wr.addr].retries <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule
